// ===== rtl/core/variable_length_record_ring_fifo_defines.svh =====
// Assertion macros for the variable-length record ring FIFO.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
// Both macros compile to nothing when SYNTH is defined.
`ifndef VARIABLE_LENGTH_RECORD_RING_FIFO_DEFINES_SVH
`define VARIABLE_LENGTH_RECORD_RING_FIFO_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define VLRF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define VLRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VLRF_ASSERT_IMPL(lbl, ante, cons, msg)
`define VLRF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/vlrf_pkg.sv =====
// Shared constants, types and pointer helpers for the record ring FIFO.
// No dependencies; imported by every module of the block but vlrf_ram.
`timescale 1ns / 1ps
`default_nettype none

package vlrf_pkg;

  localparam int RING_BYTES   = 1024;
  localparam int HEADER_BYTES = 2;
  localparam int MAX_RECORD   = 64;

  localparam int RING_AW   = $clog2(RING_BYTES);
  localparam int FREE_W    = $clog2(RING_BYTES + 1);
  localparam int LEN_W     = 7;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int AMT_W     = $clog2(HEADER_BYTES + MAX_RECORD + 1);
  localparam int HDR_CNT_W = $clog2(HEADER_BYTES + 1);
  localparam int PSUM_W    = ((RING_AW > AMT_W) ? RING_AW : AMT_W) + 1;
  localparam int CMP_W     = ((FREE_W > LEN_W + 4) ? FREE_W : LEN_W + 4) + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [FREE_W-1:0]    RING_FREE    = FREE_W'(RING_BYTES);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HEADER_BYTES - 1);
  localparam logic [HDR_CNT_W-1:0] HDR_DATA_IDX = HDR_CNT_W'(HEADER_BYTES);
  localparam logic [Q_CNT_W-1:0]   Q_FULL_CNT   = Q_CNT_W'(Q_DEPTH);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_DROP  = 3'd3,
    ST_BUSY  = 3'd4
  } status_t;

  typedef enum logic {
    FR_IDLE,
    FR_HDR
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_ZERO,
    BK_EMIT
  } bk_state_t;

  // One queued job: either a finished one-word result or a pop to run.
  typedef struct packed {
    logic              run_pop;
    status_t           status;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
    logic [LEN_W-1:0]  read_limit;
  } q_entry_t;

  // Back end to front end: space released by a pop, and pop finished.
  typedef struct packed {
    logic             rel_valid;
    logic [AMT_W-1:0] rel_amt;
    logic             done;
  } bk2fr_t;

  // Front end status seen by the back end.
  typedef struct packed {
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
    logic              pop_pend;
  } fr_stat_t;

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
    logic [RING_AW:0] s;
    s = {1'b0, p} + (RING_AW + 1)'(1);
    if (s == RING_BYTES[RING_AW:0]) begin
      s = '0;
    end
    return s[RING_AW-1:0];
  endfunction

  // Valid when p + amt stays below twice the ring size.
  function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] p,
                                                  input logic [AMT_W-1:0]   amt);
    logic [PSUM_W-1:0] s;
    s = PSUM_W'(p) + PSUM_W'(amt);
    if (s >= PSUM_W'(RING_BYTES)) begin
      s = s - PSUM_W'(RING_BYTES);
    end
    return s[RING_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vlrf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vlrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/vlrf_queue.sv =====
// Short job queue between the front and back ends of the record FIFO.
// Depends on vlrf_pkg (q_entry_t, queue depth constants).
`timescale 1ns / 1ps
`default_nettype none

module vlrf_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire vlrf_pkg::q_entry_t push_data,
  input  wire logic               pop,
  output vlrf_pkg::q_entry_t      pop_data,
  output logic                    full,
  output logic                    not_empty
);

  import vlrf_pkg::*;

  q_entry_t          entries_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r,   cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = entries_r[rd_ptr_r];
  assign full      = (cnt_r == Q_FULL_CNT);
  assign not_empty = (cnt_r != '0);

endmodule

`default_nettype wire

// ===== rtl/core/vlrf_front.sv =====
// Front end: accepts input words, keeps push state and free space, writes the ring.
// Depends on vlrf_pkg; feeds vlrf_queue and the ring RAM write port.
`timescale 1ns / 1ps
`default_nettype none

module vlrf_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_func,
  input  wire logic                         in_first,
  input  wire logic [vlrf_pkg::LEN_W-1:0]   in_rec_len,
  input  wire logic [vlrf_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic [vlrf_pkg::LEN_W-1:0]   in_read_limit,
  input  wire logic                         q_full,
  output logic                              q_push,
  output vlrf_pkg::q_entry_t                q_data,
  output logic                              ram_we,
  output logic [vlrf_pkg::RING_AW-1:0]      ram_waddr,
  output logic [vlrf_pkg::BYTE_W-1:0]       ram_wdata,
  input  wire vlrf_pkg::bk2fr_t             bk,
  output vlrf_pkg::fr_stat_t                stat
);

  import vlrf_pkg::*;

  fr_state_t            state_r,   state_nxt;
  logic [RING_AW-1:0]   tail_r,    tail_nxt;
  logic [FREE_W-1:0]    free_r,    free_nxt;
  logic [LEN_W-1:0]     pend_r,    pend_nxt;
  logic                 drop_r,    drop_nxt;
  logic                 pop_pend_r, pop_pend_nxt;
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]     len_r,     len_nxt;
  logic [BYTE_W-1:0]    byte_r,    byte_nxt;

  logic             accept;
  logic             start_rec;
  logic             hdr_done;
  logic [CMP_W-1:0] need;
  logic             refuse;
  logic [LEN_W-1:0] rec_pend;
  logic [LEN_W-1:0] pend_dec;

  assign in_stall = (state_r != FR_IDLE) | q_full | pop_pend_r;
  assign accept   = in_valid & ~in_stall;

  assign need     = CMP_W'(HEADER_BYTES) + CMP_W'(in_rec_len);
  assign refuse   = (in_rec_len > LEN_W'(MAX_RECORD)) | (CMP_W'(free_r) < need);
  assign rec_pend = (in_rec_len != '0) ? in_rec_len - LEN_W'(1) : '0;
  assign pend_dec = pend_r - LEN_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: begin
        if (start_rec) begin
          state_nxt = FR_HDR;
        end
      end
      FR_HDR: begin
        if (hdr_done) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    tail_nxt     = tail_r;
    free_nxt     = free_r;
    pend_nxt     = pend_r;
    drop_nxt     = drop_r;
    pop_pend_nxt = pop_pend_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_nxt      = len_r;
    byte_nxt     = byte_r;
    ram_we       = 1'b0;
    ram_waddr    = tail_r;
    ram_wdata    = in_data_byte;
    q_push       = 1'b0;
    q_data       = '0;
    start_rec    = 1'b0;
    hdr_done     = 1'b0;

    // released space and pop completion never coincide with an accept
    if (bk.rel_valid) begin
      free_nxt = free_r + FREE_W'(bk.rel_amt);
    end
    if (bk.done) begin
      pop_pend_nxt = 1'b0;
    end

    case (state_r)
      FR_IDLE: begin
        if (accept) begin
          q_push            = 1'b1;
          q_data.read_limit = in_read_limit;
          if (in_func == FUNC_POP) begin
            if (pend_r != '0) begin
              q_data.status = ST_BUSY;
            end else if (free_r == RING_FREE) begin
              q_data.status = ST_EMPTY;
            end else begin
              q_data.status  = ST_OK;
              q_data.run_pop = 1'b1;
              pop_pend_nxt   = 1'b1;
            end
          end else if (in_first) begin
            if (pend_r != '0 && !drop_r) begin
              q_data.status = ST_BUSY;
            end else if (refuse) begin
              q_data.status = ST_FULL;
              pend_nxt      = rec_pend;
              drop_nxt      = (rec_pend != '0);
            end else begin
              q_data.status = ST_OK;
              free_nxt      = free_r - FREE_W'(need);
              pend_nxt      = rec_pend;
              drop_nxt      = 1'b0;
              len_nxt       = in_rec_len;
              byte_nxt      = in_data_byte;
              start_rec     = 1'b1;
            end
          end else if (pend_r == '0) begin
            q_data.status = ST_DROP;
          end else begin
            pend_nxt = pend_dec;
            if (drop_r) begin
              q_data.status = ST_DROP;
              if (pend_dec == '0) begin
                drop_nxt = 1'b0;
              end
            end else begin
              q_data.status = ST_OK;
              ram_we        = 1'b1;
              tail_nxt      = ring_inc(tail_r);
            end
          end
        end
      end
      FR_HDR: begin
        // header bytes little-endian, then the record's first data byte
        ram_we   = 1'b1;
        tail_nxt = ring_inc(tail_r);
        if (hdr_cnt_r == HDR_DATA_IDX) begin
          ram_wdata = byte_r;
        end else if (hdr_cnt_r == '0) begin
          ram_wdata = BYTE_W'(len_r);
        end else begin
          ram_wdata = '0;
        end
        hdr_done = (hdr_cnt_r == HDR_DATA_IDX) ||
                   ((hdr_cnt_r == HDR_LAST_IDX) && (len_r == '0));
        hdr_cnt_nxt = hdr_done ? '0 : hdr_cnt_r + HDR_CNT_W'(1);
      end
      default: ;
    endcase

    q_data.free_bytes = free_nxt;
    q_data.is_empty   = (free_nxt == RING_FREE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_IDLE;
      tail_r     <= '0;
      free_r     <= RING_FREE;
      pend_r     <= '0;
      drop_r     <= 1'b0;
      pop_pend_r <= 1'b0;
      hdr_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      tail_r     <= tail_nxt;
      free_r     <= free_nxt;
      pend_r     <= pend_nxt;
      drop_r     <= drop_nxt;
      pop_pend_r <= pop_pend_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    byte_r <= byte_nxt;
  end

  assign stat.free_bytes = free_r;
  assign stat.is_empty   = (free_r == RING_FREE);
  assign stat.pop_pend   = pop_pend_r;

endmodule

`default_nettype wire

// ===== rtl/core/vlrf_back.sv =====
// Back end: drains the job queue, runs pops from the ring, drives the result register.
// Depends on vlrf_pkg; reads the ring RAM and reports released space to vlrf_front.
`timescale 1ns / 1ps
`default_nettype none

module vlrf_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire vlrf_pkg::q_entry_t            q_data,
  output logic                               q_pop,
  output logic                               ram_re,
  output logic [vlrf_pkg::RING_AW-1:0]       ram_raddr,
  input  wire logic [vlrf_pkg::BYTE_W-1:0]   ram_rdata,
  input  wire vlrf_pkg::fr_stat_t            fr,
  output vlrf_pkg::bk2fr_t                   bk,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vlrf_pkg::STATUS_W-1:0]      out_status,
  output logic [vlrf_pkg::BYTE_W-1:0]        out_out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last,
  output logic [vlrf_pkg::FREE_W-1:0]        out_free_bytes,
  output logic                               out_is_empty
);

  import vlrf_pkg::*;

  bk_state_t          state_r, state_nxt;
  logic [RING_AW-1:0] head_r,  head_nxt;
  logic [RING_AW-1:0] p_r,     p_nxt;
  logic [LEN_W-1:0]   cnt_r,   cnt_nxt;
  logic [LEN_W-1:0]   limit_r, limit_nxt;

  logic              ov_r;
  status_t           ostat_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              obv_r;
  logic              olast_r;
  logic [FREE_W-1:0] ofree_r;
  logic              oempty_r;

  logic              can_load;
  logic              ld;
  status_t           ld_status;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_bv;
  logic              ld_last;
  logic [FREE_W-1:0] ld_free;
  logic              ld_empty;

  logic [LEN_W-1:0]   lenc;
  logic [LEN_W-1:0]   n_out;
  logic [RING_AW-1:0] p_start;

  assign can_load = ~ov_r | ~out_stall;

  // header low byte holds the whole length; upper header bytes are always zero
  assign lenc    = (ram_rdata > BYTE_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                      : ram_rdata[LEN_W-1:0];
  assign n_out   = (limit_r < lenc) ? limit_r : lenc;
  assign p_start = ring_add(head_r, AMT_W'(HEADER_BYTES));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_data.run_pop) begin
          state_nxt = BK_LEN;
        end
      end
      BK_LEN: begin
        state_nxt = (n_out == '0) ? BK_ZERO : BK_EMIT;
      end
      BK_ZERO: begin
        if (can_load) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (can_load && cnt_r == LEN_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    bk        = '0;
    head_nxt  = head_r;
    p_nxt     = p_r;
    cnt_nxt   = cnt_r;
    limit_nxt = limit_r;
    ld        = 1'b0;
    ld_status = ST_OK;
    ld_byte   = '0;
    ld_bv     = 1'b0;
    ld_last   = 1'b1;
    ld_free   = fr.free_bytes;
    ld_empty  = fr.is_empty;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_data.run_pop) begin
            q_pop     = 1'b1;
            ram_re    = 1'b1;
            limit_nxt = q_data.read_limit;
          end else if (can_load) begin
            q_pop     = 1'b1;
            ld        = 1'b1;
            ld_status = q_data.status;
            ld_free   = q_data.free_bytes;
            ld_empty  = q_data.is_empty;
          end
        end
      end
      BK_LEN: begin
        bk.rel_valid = 1'b1;
        bk.rel_amt   = AMT_W'(HEADER_BYTES) + AMT_W'(lenc);
        head_nxt     = ring_add(p_start, AMT_W'(lenc));
        if (n_out != '0) begin
          ram_re    = 1'b1;
          ram_raddr = p_start;
          p_nxt     = ring_inc(p_start);
          cnt_nxt   = n_out;
        end
      end
      BK_ZERO: begin
        if (can_load) begin
          ld      = 1'b1;
          bk.done = 1'b1;
        end
      end
      BK_EMIT: begin
        if (can_load) begin
          ld      = 1'b1;
          ld_byte = ram_rdata;
          ld_bv   = 1'b1;
          ld_last = (cnt_r == LEN_W'(1));
          cnt_nxt = cnt_r - LEN_W'(1);
          if (cnt_r == LEN_W'(1)) begin
            bk.done = 1'b1;
          end else begin
            // next byte lands in the read register as this one leaves
            ram_re    = 1'b1;
            ram_raddr = p_r;
            p_nxt     = ring_inc(p_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      head_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      ov_r    <= ld | (ov_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    cnt_r   <= cnt_nxt;
    limit_r <= limit_nxt;
    if (ld) begin
      ostat_r  <= ld_status;
      obyte_r  <= ld_byte;
      obv_r    <= ld_bv;
      olast_r  <= ld_last;
      ofree_r  <= ld_free;
      oempty_r <= ld_empty;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_out_byte   = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_last       = olast_r;
  assign out_free_bytes = ofree_r;
  assign out_is_empty   = oempty_r;

endmodule

`default_nettype wire

// ===== rtl/core/variable_length_record_ring_fifo.sv =====
// Top level of the variable-length record ring FIFO.
// Depends on vlrf_pkg, vlrf_ram, vlrf_queue, vlrf_front, vlrf_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "variable_length_record_ring_fifo_defines.svh"

// A 1024-byte ring of length-prefixed records (2-byte little-endian header, up to 64
// data bytes, both wrapping at the ring end). Push streams one word per byte; the word
// with first set carries the length and, for a non-empty record, its first byte. Pop
// returns one whole record, one output word per delivered byte up to read_limit, and
// always frees the full record. Every input word yields at least one output word, the
// final one flagged with last, and each reports status, free bytes and emptiness.
// The first word of an accepted record holds the input side while the header writes and,
// for a non-empty record, the data byte write follow, because the ring RAM has a single
// write port. A pop holds the input side from acceptance until its last byte is handed
// to the output register: it is accepted, queued and its header read, then its bytes are
// delivered one after another; results still waiting ahead of it in the queue and output
// stalls lengthen that hold. Push data bytes and refused, busy, empty and dropped words
// do not hold the input side past their acceptance. The ring is never cleared: the RAM
// powers up undefined and only written bytes are ever read back, so the block is ready
// right after reset.
module variable_length_record_ring_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic                          in_first,
  input  wire logic [vlrf_pkg::LEN_W-1:0]    in_rec_len,
  input  wire logic [vlrf_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic [vlrf_pkg::LEN_W-1:0]    in_read_limit,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vlrf_pkg::STATUS_W-1:0]      out_status,
  output logic [vlrf_pkg::BYTE_W-1:0]        out_out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last,
  output logic [vlrf_pkg::FREE_W-1:0]        out_free_bytes,
  output logic                               out_is_empty
);

  import vlrf_pkg::*;

  // job queue between front and back
  logic     q_push, q_pop, q_full, q_not_empty;
  q_entry_t q_wdata, q_rdata;

  // ring RAM ports: front writes at tail, back reads at head
  logic               ram_we, ram_re;
  logic [RING_AW-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  bk2fr_t   bk2fr;
  fr_stat_t fr_stat;

  vlrf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vlrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Front end: classifies each word, owns tail, free count and push progress.
  vlrf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_first      (in_first),
    .in_rec_len    (in_rec_len),
    .in_data_byte  (in_data_byte),
    .in_read_limit (in_read_limit),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .bk            (bk2fr),
    .stat          (fr_stat)
  );

  // Back end: owns head, runs pops and drives the output register.
  vlrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .fr             (fr_stat),
    .bk             (bk2fr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_out_byte   (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_free_bytes (out_free_bytes),
    .out_is_empty   (out_is_empty)
  );

  // While a pop is in flight no word may enter: a push could overwrite freed bytes
  // that are still being read.
  `VLRF_ASSERT_IMPL(a_pop_holds_input, fr_stat.pop_pend, in_stall, "word accepted during pop")
  // Space is released only by a pop the front end launched.
  `VLRF_ASSERT_IMPL(a_release_in_pop, bk2fr.rel_valid, fr_stat.pop_pend, "stray space release")
  // The empty flag always agrees with the reported free count.
  `VLRF_ASSERT_IMPL(a_empty_matches_free, out_valid, out_is_empty == (out_free_bytes == RING_FREE), "empty flag disagrees with free count")
  // Pop completion reopens the input side on the next cycle.
  `VLRF_ASSERT_NEXT(a_done_clears_pend, bk2fr.done, !fr_stat.pop_pend, "pop done did not clear pending")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for variable_length_record_ring_fifo: a directed table and a mixed
// random phase, scored against a behavioral ring model or, for typed rows, hand results.
// Depends on vlrf_pkg and the RTL of the block; reads no files.
module tb;
  import vlrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int MIXED_WORDS    = 330;
  localparam int QUIET_WORDS    = 60;
  localparam int SETTLE_CYCLES  = 40;

  // one input word
  typedef struct packed {
    logic              func;
    logic              first;
    logic [LEN_W-1:0]  rec_len;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  read_limit;
  } fifo_word_t;

  // one result word
  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
  } fifo_res_t;

  // directed row; typed rows carry their single result word by hand
  typedef struct packed {
    fifo_word_t        word;
    logic              typed;
    status_t           status;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
  } dir_row_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                in_func        = FUNC_PUSH;
  logic                in_first       = 1'b0;
  logic [LEN_W-1:0]    in_rec_len     = '0;
  logic [BYTE_W-1:0]   in_data_byte   = '0;
  logic [LEN_W-1:0]    in_read_limit  = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_out_byte;
  logic                out_byte_valid;
  logic                out_last;
  logic [FREE_W-1:0]   out_free_bytes;
  logic                out_is_empty;

  // ring model state
  logic [BYTE_W-1:0] ring_copy [RING_BYTES];
  int unsigned       wr_pos       = 0;
  int unsigned       rd_pos       = 0;
  int unsigned       free_left    = RING_BYTES;
  int unsigned       bytes_owed   = 0;
  bit                dropping_rec = 1'b0;

  fifo_res_t   model_words[$];  // words caused by the last accepted input word
  fifo_res_t   due_words[$];    // words still to come out of the block
  int unsigned words_sent   = 0;
  int unsigned words_seen   = 0;
  int unsigned mismatches   = 0;
  bit          hold_off_req = 1'b0;
  bit          quiet_tail   = 1'b0;

  dir_row_t directed_rows [21] = '{
    // pop after reset: empty
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd0},   1'b1, ST_EMPTY, 11'd1024, 1'b1},
    // stray byte, nothing in progress
    '{'{FUNC_PUSH, 1'b0, 7'd0,   8'h12, 7'd0},   1'b1, ST_DROP,  11'd1024, 1'b1},
    // zero-length record: header only, data ignored
    '{'{FUNC_PUSH, 1'b1, 7'd0,   8'hFF, 7'd0},   1'b1, ST_OK,    11'd1022, 1'b0},
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd127}, 1'b1, ST_OK,    11'd1024, 1'b1},
    '{'{FUNC_PUSH, 1'b1, 7'd3,   8'hFF, 7'd0},   1'b1, ST_OK,    11'd1019, 1'b0},
    // pop and new record while the record is unfinished: busy
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd64},  1'b1, ST_BUSY,  11'd1019, 1'b0},
    '{'{FUNC_PUSH, 1'b1, 7'd2,   8'h11, 7'd0},   1'b1, ST_BUSY,  11'd1019, 1'b0},
    '{'{FUNC_PUSH, 1'b0, 7'd0,   8'h00, 7'd0},   1'b1, ST_OK,    11'd1019, 1'b0},
    '{'{FUNC_PUSH, 1'b0, 7'd0,   8'hA5, 7'd0},   1'b1, ST_OK,    11'd1019, 1'b0},
    '{'{FUNC_PUSH, 1'b0, 7'd0,   8'h3C, 7'd0},   1'b1, ST_DROP,  11'd1019, 1'b0},
    // too long: refused, its bytes dropped, pops busy while dropping
    '{'{FUNC_PUSH, 1'b1, 7'd65,  8'h01, 7'd0},   1'b1, ST_FULL,  11'd1019, 1'b0},
    '{'{FUNC_PUSH, 1'b0, 7'd0,   8'h02, 7'd0},   1'b1, ST_DROP,  11'd1019, 1'b0},
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd10},  1'b1, ST_BUSY,  11'd1019, 1'b0},
    // new record ends the dropping
    '{'{FUNC_PUSH, 1'b1, 7'd127, 8'h00, 7'd0},   1'b1, ST_FULL,  11'd1019, 1'b0},
    '{'{FUNC_PUSH, 1'b1, 7'd1,   8'h80, 7'd0},   1'b1, ST_OK,    11'd1016, 1'b0},
    // limit zero still frees the record
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd0},   1'b1, ST_OK,    11'd1021, 1'b0},
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd2},   1'b0, ST_OK,    11'd0,    1'b0},
    '{'{FUNC_PUSH, 1'b1, 7'd2,   8'h7F, 7'd0},   1'b0, ST_OK,    11'd0,    1'b0},
    '{'{FUNC_PUSH, 1'b0, 7'd0,   8'hC3, 7'd0},   1'b0, ST_OK,    11'd0,    1'b0},
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd127}, 1'b0, ST_OK,    11'd0,    1'b0},
    '{'{FUNC_POP,  1'b0, 7'd0,   8'h00, 7'd1},   1'b1, ST_EMPTY, 11'd1024, 1'b1}
  };

  variable_length_record_ring_fifo dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_first      (in_first),
    .in_rec_len    (in_rec_len),
    .in_data_byte  (in_data_byte),
    .in_read_limit (in_read_limit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_out_byte  (out_out_byte),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last),
    .out_free_bytes(out_free_bytes),
    .out_is_empty  (out_is_empty)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1) % RING_BYTES;
  endfunction

  function automatic void add_word(input status_t st, input logic [BYTE_W-1:0] b,
                                   input logic bv, input logic lst);
    model_words.push_back('{st, b, bv, lst, FREE_W'(free_left), free_left == RING_BYTES});
  endfunction

  // Expected result words of one accepted input word; updates the ring model.
  function automatic void predict_fifo_words(input fifo_word_t w);
    int unsigned       len;
    int unsigned       n;
    int unsigned       p;
    logic [BYTE_W-1:0] rec [MAX_RECORD];
    status_t           st;
    model_words.delete();
    if (w.func == FUNC_PUSH) begin
      len = w.rec_len;
      if (w.first) begin
        if (bytes_owed != 0 && !dropping_rec) begin
          st = ST_BUSY;
        end else begin
          dropping_rec = 1'b0;
          bytes_owed   = 0;
          if (len > MAX_RECORD || free_left < HEADER_BYTES + len) begin
            st = ST_FULL;
            if (len != 0) begin
              bytes_owed   = len - 1;
              dropping_rec = (bytes_owed != 0);
            end
          end else begin
            // little-endian header, then the first data byte
            for (int i = 0; i < HEADER_BYTES; i++) begin
              ring_copy[wr_pos] = BYTE_W'(len >> (8 * i));
              wr_pos = ring_next(wr_pos);
            end
            free_left -= HEADER_BYTES + len;
            if (len != 0) begin
              ring_copy[wr_pos] = w.data_byte;
              wr_pos     = ring_next(wr_pos);
              bytes_owed = len - 1;
            end
            st = ST_OK;
          end
        end
      end else if (bytes_owed == 0) begin
        st = ST_DROP;
      end else begin
        bytes_owed--;
        if (dropping_rec) begin
          if (bytes_owed == 0) dropping_rec = 1'b0;
          st = ST_DROP;
        end else begin
          ring_copy[wr_pos] = w.data_byte;
          wr_pos = ring_next(wr_pos);
          st = ST_OK;
        end
      end
      add_word(st, 8'h00, 1'b0, 1'b1);
    end else if (bytes_owed != 0) begin
      add_word(ST_BUSY, 8'h00, 1'b0, 1'b1);
    end else if (free_left >= RING_BYTES) begin
      add_word(ST_EMPTY, 8'h00, 1'b0, 1'b1);
    end else begin
      len = 0;
      p   = rd_pos;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        len = len | (int'(ring_copy[p]) << (8 * i));
        p = ring_next(p);
      end
      if (len > MAX_RECORD) len = MAX_RECORD;
      for (int i = 0; i < len; i++) begin
        rec[i] = ring_copy[p];
        p = ring_next(p);
      end
      rd_pos = p;
      // whole record is freed, whatever the limit
      free_left += HEADER_BYTES + len;
      if (free_left > RING_BYTES) free_left = RING_BYTES;
      n = (w.read_limit < len) ? w.read_limit : len;
      if (n == 0) add_word(ST_OK, 8'h00, 1'b0, 1'b1);
      for (int i = 0; i < n; i++) begin
        add_word(ST_OK, rec[i], 1'b1, (i + 1) == n);
      end
    end
  endfunction

  function automatic fifo_word_t noise_word();
    return fifo_word_t'($bits(fifo_word_t)'($urandom));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 70) return $urandom_range(1, 16);
    if (r < 94) return $urandom_range(17, MAX_RECORD);
    return $urandom_range(MAX_RECORD + 1, 127);
  endfunction

  function automatic int unsigned pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, MAX_RECORD);
    return $urandom_range(MAX_RECORD + 1, 127);
  endfunction

  // Offer one word, hold it until accepted, then book its expected results.
  task automatic send_word(input fifo_word_t w, input bit typed, input fifo_res_t typed_res,
                           output status_t first_status);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= w.func;
    in_first      <= w.first;
    in_rec_len    <= w.rec_len;
    in_data_byte  <= w.data_byte;
    in_read_limit <= w.read_limit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fifo_words(w);
    first_status = model_words[0].status;
    if (typed) begin
      due_words.push_back(typed_res);
    end else begin
      foreach (model_words[i]) due_words.push_back(model_words[i]);
    end
    words_sent++;
  endtask

  task automatic offer(input fifo_word_t w, output status_t st);
    send_word(w, 1'b0, '0, st);
  endtask

  task automatic push_data();
    fifo_word_t w;
    status_t    st;
    w = noise_word();
    w.func  = FUNC_PUSH;
    w.first = 1'b0;
    offer(w, st);
  endtask

  task automatic pop_record(input int unsigned limit);
    fifo_word_t w;
    status_t    st;
    w = noise_word();
    w.func       = FUNC_POP;
    w.read_limit = LEN_W'(limit);
    offer(w, st);
  endtask

  // Whole record; optionally a busy pop and a busy restart land mid-record.
  task automatic push_record(input int unsigned len, input bit interrupt);
    fifo_word_t  w;
    status_t     st;
    int unsigned cut;
    w = noise_word();
    w.func    = FUNC_PUSH;
    w.first   = 1'b1;
    w.rec_len = LEN_W'(len);
    offer(w, st);
    if (st != ST_OK) begin
      // refused: a few of its bytes follow and get dropped
      repeat ($urandom_range(0, 3)) push_data();
      return;
    end
    cut = (interrupt && len > 2) ? $urandom_range(1, len - 2) : 0;
    for (int i = 1; i < len; i++) begin
      if (i == cut) begin
        pop_record(pick_limit());
        w = noise_word();
        w.func  = FUNC_PUSH;
        w.first = 1'b1;
        offer(w, st);
      end
      push_data();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("mismatch at result word %0d: %s got %0h expected %0h",
             words_seen, what, got, want);
  endtask

  task automatic check_result();
    fifo_res_t want;
    words_seen++;
    if (due_words.size() == 0) begin
      report_mismatch("unexpected word, status", 16'(out_status), 16'h0);
      return;
    end
    want = due_words.pop_front();
    if (out_status !== want.status)
      report_mismatch("status", 16'(out_status), 16'(want.status));
    if (out_out_byte !== want.out_byte)
      report_mismatch("out_byte", 16'(out_out_byte), 16'(want.out_byte));
    if (out_byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", 16'(out_byte_valid), 16'(want.byte_valid));
    if (out_last !== want.last)
      report_mismatch("last", 16'(out_last), 16'(want.last));
    if (out_free_bytes !== want.free_bytes)
      report_mismatch("free_bytes", 16'(out_free_bytes), 16'(want.free_bytes));
    if (out_is_empty !== want.is_empty)
      report_mismatch("is_empty", 16'(out_is_empty), 16'(want.is_empty));
  endtask

  // Result side: score accepted words, stall in random bursts, one long hold-off.
  initial begin : result_side
    int unsigned hold_left;
    bit          long_done;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result();
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_off_req && !long_done) begin
        // sender keeps offering, so the block backs up and stalls its input
        long_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when no word moves on either side for too long.
  initial begin : watchdog
    int unsigned still_cycles;
    still_cycles = 0;
    while (still_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) still_cycles = 0;
      else still_cycles++;
    end
    $display("variable_length_record_ring_fifo test failed");
    $finish;
  end

  initial begin : stimulus
    fifo_res_t   typed_res;
    status_t     st;
    fifo_word_t  w;
    int unsigned mixed_start;
    int unsigned r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res = '{directed_rows[i].status, 8'h00, 1'b0, 1'b1,
                    directed_rows[i].free_bytes, directed_rows[i].is_empty};
      send_word(directed_rows[i].word, directed_rows[i].typed, typed_res, st);
    end

    // the long hold-off lands at the start of the mixed phase
    hold_off_req = 1'b1;

    mixed_start = words_sent;
    while (words_sent < mixed_start + MIXED_WORDS) begin
      if (words_sent >= mixed_start + MIXED_WORDS - QUIET_WORDS) quiet_tail = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 52) begin
        push_record(pick_len(), $urandom_range(0, 7) == 0);
      end else if (r < 85) begin
        pop_record(pick_limit());
      end else begin
        // stray bytes and pops with random content, never a record start
        w = noise_word();
        if (w.func == FUNC_PUSH) w.first = 1'b0;
        offer(w, st);
      end
    end
    in_valid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("variable_length_record_ring_fifo test passed");
    end else begin
      $display("variable_length_record_ring_fifo test failed");
    end
    $finish;
  end

endmodule
